>>> design/etfi_pkg.sv
// Shared types and constants for the escape-time fractal iterator.
// Used by etfi_seq and escape_time_fractal_iterator_top.
`timescale 1ns / 1ps
`default_nettype none

package etfi_pkg;

   // Register index map of the CSR write port
   localparam int unsigned CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_X_ORIGIN       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_Y_ORIGIN       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_X_STEP         = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_Y_STEP         = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PARAM_RE       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PARAM_IM       = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_ITERATIONS = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PLANE_MODE     = 3'd7;

   // Plane modes
   localparam int unsigned MODE_WIDTH = 3;

   localparam logic [MODE_WIDTH-1:0] MODE_MANDELBROT = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_JULIA      = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_MIX_A      = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_MIX_B      = 3'd4;

   // Band limits of the mixed-B mode, 60 fraction bits (about 0.100167 and 3.041425)
   localparam logic [63:0] BAND_LOW_Q60  = 64'd115485173918184697;
   localparam logic [63:0] BAND_HIGH_Q60 = 64'd3506524555119540928;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_PX,
      ST_MUL_PY,
      ST_SETUP,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_CROSS,
      ST_UPDATE
   } state_type;

endpackage

`default_nettype wire

>>> design/escape_time_fractal_iterator_top.sv
// Escape-time fractal iterator (Mandelbrot, Julia and mixed planes) in Q4.28.
// A request is taken when start is high and busy is low. The answer appears on
// rsp_iteration_count for exactly one cycle with rsp_valid high; the receiver
// cannot stall it. A request first maps the pixel with two products, then makes
// k loop passes, where k is the count, or the count plus one when the point
// escapes. The one shared multiplier serves every product: each pass needs
// three products (zr*zr, zi*zi, zr*zi) plus an update step.
// busy drops in the cycle the result is shown, so a new request may start then.
// Depends on etfi_pkg, etfi_mul and etfi_seq.
`timescale 1ns / 1ps
`default_nettype none

module escape_time_fractal_iterator_top #(
   parameter int unsigned FRAC_BITS   = 28,
   parameter int unsigned COORD_WIDTH = 32,
   parameter int unsigned PIXEL_WIDTH = 12,
   parameter int unsigned ITER_WIDTH  = 16,
   localparam int unsigned CSR_WIDTH  = (COORD_WIDTH > ITER_WIDTH) ? COORD_WIDTH : ITER_WIDTH
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // request
   input  wire logic                                      start,
   output logic                                           busy,
   input  wire logic [PIXEL_WIDTH-1:0]                    req_pixel_x,
   input  wire logic [PIXEL_WIDTH-1:0]                    req_pixel_y,
   // response
   output logic                                           rsp_valid,
   output logic [ITER_WIDTH-1:0]                          rsp_iteration_count,
   // register writes
   input  wire logic                                      csr_we,
   input  wire logic [etfi_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  wire logic [CSR_WIDTH-1:0]                      csr_wdata
);

   localparam logic [COORD_WIDTH-1:0] TWO_Q       = COORD_WIDTH'(2) << FRAC_BITS;
   localparam logic [COORD_WIDTH-1:0] ORIGIN_RST  = -TWO_Q;
   localparam logic [COORD_WIDTH-2:0] STEP_RST    = (COORD_WIDTH-1)'(1) << (FRAC_BITS - 10);
   localparam logic [ITER_WIDTH-1:0]  MAX_ITER_RST = ITER_WIDTH'(50);

   logic signed [COORD_WIDTH-1:0]          x_origin_ff;
   logic signed [COORD_WIDTH-1:0]          y_origin_ff;
   logic [COORD_WIDTH-2:0]                 x_step_ff;
   logic [COORD_WIDTH-2:0]                 y_step_ff;
   logic signed [COORD_WIDTH-1:0]          param_re_ff;
   logic signed [COORD_WIDTH-1:0]          param_im_ff;
   logic [ITER_WIDTH-1:0]                  max_iter_ff;
   logic [etfi_pkg::MODE_WIDTH-1:0]        mode_ff;

   logic signed [COORD_WIDTH-1:0]          mul_a;
   logic signed [COORD_WIDTH-1:0]          mul_b;
   logic signed [2*COORD_WIDTH-1:0]        mul_prod;

   // Settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= ORIGIN_RST;
         y_origin_ff <= ORIGIN_RST;
         x_step_ff   <= STEP_RST;
         y_step_ff   <= STEP_RST;
         param_re_ff <= '0;
         param_im_ff <= '0;
         max_iter_ff <= MAX_ITER_RST;
         mode_ff     <= etfi_pkg::MODE_MANDELBROT;
      end else if (csr_we) begin
         unique case (csr_index)
            etfi_pkg::REG_X_ORIGIN:       x_origin_ff <= csr_wdata[COORD_WIDTH-1:0];
            etfi_pkg::REG_Y_ORIGIN:       y_origin_ff <= csr_wdata[COORD_WIDTH-1:0];
            etfi_pkg::REG_X_STEP:         x_step_ff   <= csr_wdata[COORD_WIDTH-2:0];
            etfi_pkg::REG_Y_STEP:         y_step_ff   <= csr_wdata[COORD_WIDTH-2:0];
            etfi_pkg::REG_PARAM_RE:       param_re_ff <= csr_wdata[COORD_WIDTH-1:0];
            etfi_pkg::REG_PARAM_IM:       param_im_ff <= csr_wdata[COORD_WIDTH-1:0];
            etfi_pkg::REG_MAX_ITERATIONS: max_iter_ff <= csr_wdata[ITER_WIDTH-1:0];
            etfi_pkg::REG_PLANE_MODE:     mode_ff     <= csr_wdata[etfi_pkg::MODE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Shared multiplier
   etfi_mul #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   // Sequencer and datapath
   etfi_seq #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH),
      .PIXEL_WIDTH (PIXEL_WIDTH),
      .ITER_WIDTH  (ITER_WIDTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .pixel_x        (req_pixel_x),
      .pixel_y        (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_count      (rsp_iteration_count),
      .x_origin       (x_origin_ff),
      .y_origin       (y_origin_ff),
      .x_step         (x_step_ff),
      .y_step         (y_step_ff),
      .param_re       (param_re_ff),
      .param_im       (param_im_ff),
      .max_iterations (max_iter_ff),
      .plane_mode     (mode_ff),
      .mul_a          (mul_a),
      .mul_b          (mul_b),
      .mul_prod       (mul_prod)
   );

endmodule

`default_nettype wire

>>> design/etfi_mul.sv
// Shared signed multiplier with registered product.
// Standalone; driven by etfi_seq through the top level.
`timescale 1ns / 1ps
`default_nettype none

module etfi_mul #(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  wire logic                            clock,
   input  wire logic signed [COORD_WIDTH-1:0]   op_a,
   input  wire logic signed [COORD_WIDTH-1:0]   op_b,
   output logic signed [2*COORD_WIDTH-1:0]      prod
);

   logic signed [2*COORD_WIDTH-1:0] prod_ff;
   logic signed [2*COORD_WIDTH-1:0] prod_in;

   // Full-width signed product of two coordinate-wide operands
   always_comb begin
      prod_in = op_a * op_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

>>> design/etfi_seq.sv
// Sequencer and datapath: plane mapping, mode selection and the z = z*z + c loop.
// Depends on etfi_pkg; uses the shared multiplier etfi_mul for every product.
`timescale 1ns / 1ps
`default_nettype none

module etfi_seq #(
   parameter int unsigned FRAC_BITS   = 28,
   parameter int unsigned COORD_WIDTH = 32,
   parameter int unsigned PIXEL_WIDTH = 12,
   parameter int unsigned ITER_WIDTH  = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [PIXEL_WIDTH-1:0]              pixel_x,
   input  wire logic [PIXEL_WIDTH-1:0]              pixel_y,
   // response
   output logic                                     rsp_valid,
   output logic [ITER_WIDTH-1:0]                    rsp_count,
   // settings
   input  wire logic signed [COORD_WIDTH-1:0]       x_origin,
   input  wire logic signed [COORD_WIDTH-1:0]       y_origin,
   input  wire logic [COORD_WIDTH-2:0]              x_step,
   input  wire logic [COORD_WIDTH-2:0]              y_step,
   input  wire logic signed [COORD_WIDTH-1:0]       param_re,
   input  wire logic signed [COORD_WIDTH-1:0]       param_im,
   input  wire logic [ITER_WIDTH-1:0]               max_iterations,
   input  wire logic [etfi_pkg::MODE_WIDTH-1:0]     plane_mode,
   // shared multiplier
   output logic signed [COORD_WIDTH-1:0]            mul_a,
   output logic signed [COORD_WIDTH-1:0]            mul_b,
   input  wire logic signed [2*COORD_WIDTH-1:0]     mul_prod
);

   localparam int unsigned W  = COORD_WIDTH;
   localparam int unsigned W2 = 2 * COORD_WIDTH;

   localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

   localparam logic [63:0] FOUR_Q  = 64'd4 << FRAC_BITS;
   localparam logic [63:0] BAND_LO = etfi_pkg::BAND_LOW_Q60 >> (60 - FRAC_BITS);
   localparam logic [63:0] BAND_HI = etfi_pkg::BAND_HIGH_Q60 >> (60 - FRAC_BITS);

   // Saturating add
   function automatic logic signed [W-1:0] sat_add(
      input logic signed [W-1:0] a,
      input logic signed [W-1:0] b
   );
      logic signed [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) begin
         return s[W] ? CMIN : CMAX;
      end
      return s[W-1:0];
   endfunction

   // Saturating subtract
   function automatic logic signed [W-1:0] sat_sub(
      input logic signed [W-1:0] a,
      input logic signed [W-1:0] b
   );
      logic signed [W:0] s;
      s = {a[W-1], a} - {b[W-1], b};
      if (s[W] != s[W-1]) begin
         return s[W] ? CMIN : CMAX;
      end
      return s[W-1:0];
   endfunction

   // Narrow a shifted product to the coordinate range with saturation
   function automatic logic signed [W-1:0] sat_narrow(input logic signed [W2-1:0] v);
      logic [W:0] top;
      top = v[W2-1:W-1];
      if ((top != '0) && (top != '1)) begin
         return v[W2-1] ? CMIN : CMAX;
      end
      return v[W-1:0];
   endfunction

   // origin + pixel*step, the non-negative product saturated first
   function automatic logic signed [W-1:0] plane_point(
      input logic signed [W-1:0]  origin,
      input logic signed [W2-1:0] p
   );
      logic signed [W-1:0] off;
      if (p[W2-1:W-1] != '0) begin
         off = CMAX;
      end else begin
         off = p[W-1:0];
      end
      return sat_add(origin, off);
   endfunction

   etfi_pkg::state_type state_ff, state_in;

   logic                      valid_ff, valid_in;
   logic [ITER_WIDTH-1:0]     count_ff, count_in;
   logic [PIXEL_WIDTH-1:0]    pix_x_ff, pix_x_in;
   logic [PIXEL_WIDTH-1:0]    pix_y_ff, pix_y_in;
   logic signed [W-1:0]       px_ff, px_in;
   logic signed [W-1:0]       cr_ff, cr_in;
   logic signed [W-1:0]       ci_ff, ci_in;
   logic signed [W-1:0]       zr_ff, zr_in;
   logic signed [W-1:0]       zi_ff, zi_in;
   logic signed [W-1:0]       r2_ff, r2_in;
   logic signed [W-1:0]       i2_ff, i2_in;
   logic [ITER_WIDTH-1:0]     n_ff, n_in;

   // Per-iteration arithmetic
   logic signed [W-1:0]       py;
   logic signed [W-1:0]       sq_post;
   logic signed [W-1:0]       mag;
   logic [63:0]               mag_ext;
   logic                      escape;
   logic                      out_of_band;
   logic signed [W-1:0]       next_zr;
   logic signed [W-1:0]       next_zi;
   logic [ITER_WIDTH-1:0]     n_inc;

   always_comb begin
      py          = plane_point(y_origin, mul_prod);
      sq_post     = sat_narrow(mul_prod >>> FRAC_BITS);
      mag         = sat_add(r2_ff, i2_ff);
      mag_ext     = 64'(mag);
      escape      = (mag_ext >= FOUR_Q);
      out_of_band = (plane_mode == etfi_pkg::MODE_MIX_B) &&
                    !((mag_ext > BAND_LO) && (mag_ext < BAND_HI));
      next_zr     = sat_add(sat_sub(r2_ff, i2_ff), cr_ff);
      next_zi     = sat_add(sat_narrow(mul_prod >>> (FRAC_BITS - 1)), ci_ff);
      n_inc       = n_ff + 1'b1;
   end

   // Multiplier operand select
   always_comb begin
      unique case (state_ff)
         etfi_pkg::ST_MUL_PX: begin
            mul_a = W'(pix_x_ff);
            mul_b = {1'b0, x_step};
         end
         etfi_pkg::ST_MUL_PY: begin
            mul_a = W'(pix_y_ff);
            mul_b = {1'b0, y_step};
         end
         etfi_pkg::ST_SQ_RE: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         etfi_pkg::ST_SQ_IM: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
      endcase
   end

   // State register and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= etfi_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      pix_x_ff <= pix_x_in;
      pix_y_ff <= pix_y_in;
      px_ff    <= px_in;
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      r2_ff    <= r2_in;
      i2_ff    <= i2_in;
      n_ff     <= n_in;
   end

   // Next state and datapath loads
   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      count_in = count_ff;
      pix_x_in = pix_x_ff;
      pix_y_in = pix_y_ff;
      px_in    = px_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      r2_in    = r2_ff;
      i2_in    = i2_ff;
      n_in     = n_ff;

      unique case (state_ff)
         etfi_pkg::ST_IDLE: begin
            if (start) begin
               pix_x_in = pixel_x;
               pix_y_in = pixel_y;
               state_in = etfi_pkg::ST_MUL_PX;
            end
         end
         etfi_pkg::ST_MUL_PX: begin
            state_in = etfi_pkg::ST_MUL_PY;
         end
         etfi_pkg::ST_MUL_PY: begin
            px_in    = plane_point(x_origin, mul_prod);
            state_in = etfi_pkg::ST_SETUP;
         end
         etfi_pkg::ST_SETUP: begin
            n_in     = '0;
            state_in = etfi_pkg::ST_SQ_RE;
            unique case (plane_mode)
               etfi_pkg::MODE_MANDELBROT: begin
                  cr_in = px_ff;    ci_in = py;
                  zr_in = param_re; zi_in = param_im;
               end
               etfi_pkg::MODE_JULIA: begin
                  cr_in = param_re; ci_in = param_im;
                  zr_in = px_ff;    zi_in = py;
               end
               etfi_pkg::MODE_MIX_A: begin
                  cr_in = param_re; ci_in = py;
                  zr_in = px_ff;    zi_in = param_im;
               end
               etfi_pkg::MODE_MIX_B: begin
                  cr_in = px_ff;    ci_in = param_im;
                  zr_in = param_re; zi_in = py;
               end
               default: begin
                  // unused mode answers zero
                  valid_in = 1'b1;
                  count_in = '0;
                  state_in = etfi_pkg::ST_IDLE;
               end
            endcase
            // zero limit answers zero
            if (max_iterations == '0) begin
               valid_in = 1'b1;
               count_in = '0;
               state_in = etfi_pkg::ST_IDLE;
            end
         end
         etfi_pkg::ST_SQ_RE: begin
            state_in = etfi_pkg::ST_SQ_IM;
         end
         etfi_pkg::ST_SQ_IM: begin
            r2_in    = sq_post;
            state_in = etfi_pkg::ST_CROSS;
         end
         etfi_pkg::ST_CROSS: begin
            i2_in    = sq_post;
            state_in = etfi_pkg::ST_UPDATE;
         end
         etfi_pkg::ST_UPDATE: begin
            if (escape || out_of_band) begin
               valid_in = 1'b1;
               count_in = n_ff;
               state_in = etfi_pkg::ST_IDLE;
            end else begin
               zr_in = next_zr;
               zi_in = next_zi;
               n_in  = n_inc;
               if (n_inc == max_iterations) begin
                  valid_in = 1'b1;
                  count_in = n_inc;
                  state_in = etfi_pkg::ST_IDLE;
               end else begin
                  state_in = etfi_pkg::ST_SQ_RE;
               end
            end
         end
         default: begin
            state_in = etfi_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != etfi_pkg::ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_count = count_ff;

endmodule

`default_nettype wire

>>> design/etfi_checker.sv
// Port-level checks on the request/response sequencing of the iterator top.
// Bound to escape_time_fractal_iterator_top; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module etfi_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   // An accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted request");

   // The response strobe lasts one cycle
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // The block is free while its response is shown
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while response shown");

   // Work ends only by delivering a response
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

endmodule

bind escape_time_fractal_iterator_top etfi_checker u_etfi_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

`default_nettype wire
